// ===== rtl/cld_pkg.sv =====
// Shared codes and default sizes for the caching lock directory.
package cld_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int CLIENT_COUNT_DEF  = 16;
  localparam int LOCK_ID_BITS_DEF  = 32;

  // Port widths fixed by the message format.
  localparam int ID_W     = 32;
  localparam int CLIENT_W = 4;
  localparam int MSG_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic KIND_ACQUIRE = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [MSG_W-1:0] MSG_REPLY  = 2'd0;
  localparam logic [MSG_W-1:0] MSG_REVOKE = 2'd1;
  localparam logic [MSG_W-1:0] MSG_RETRY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RETRY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

// ===== rtl/cld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/caching_lock_directory.sv =====
// Top level of the caching lock directory: request sequencer, table RAM and result register.
//
// The directory accepts one acquire or release request at a time and answers with one to
// three results: an optional revoke or retry callback (or both, retry first), then the
// reply, which always carries last = 1. Lock entries live in a single RAM and are filled
// from index 0 upward and never freed, so a fill count marks the valid entries and no
// clearing pass is needed after reset. A request scans the filled entries through the
// RAM read port, one entry per cycle, comparing each stored lock id with the shared
// comparator; the entry is then written back in the update state. A release that finds
// the lock then walks the waiter mask one bit per cycle to find the lowest waiter and
// whether another one waits, stopping at the second set bit or once no set bit remains.
// Each result then passes through the output register and waits there while the consumer
// holds rsp_stall. The next request is accepted while the final reply still waits in the
// output register. A request seen while the directory works is held off by req_stall. An
// acquire of an unknown lock with no free entry returns FULL.
module caching_lock_directory #(
  parameter int TABLE_ENTRIES = cld_pkg::TABLE_ENTRIES_DEF,
  parameter int CLIENT_COUNT  = cld_pkg::CLIENT_COUNT_DEF,
  parameter int LOCK_ID_BITS  = cld_pkg::LOCK_ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          kind,
  input  logic [cld_pkg::ID_W-1:0]      lock_id,
  input  logic [cld_pkg::CLIENT_W-1:0]  client,
  // result channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [cld_pkg::MSG_W-1:0]     message,
  output logic [cld_pkg::CLIENT_W-1:0]  target_client,
  output logic [cld_pkg::ID_W-1:0]      about_lock,
  output logic [cld_pkg::STATUS_W-1:0]  status,
  output logic                          last
);

  import cld_pkg::*;

  // Only the low LOCK_ID_BITS of the 32-bit lock id take part in lookup.
  localparam int KEY_W  = (LOCK_ID_BITS < ID_W) ? LOCK_ID_BITS : ID_W;
  localparam int AW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int CIDX_W = (CLIENT_COUNT > 1) ? $clog2(CLIENT_COUNT) : 1;
  // Entry record: {lock, held, holder, revoke_sent, waiters}
  localparam int REC_W  = KEY_W + 1 + CLIENT_W + 1 + CLIENT_COUNT;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_BITS = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]              state;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        ridx;
  logic                    pend;
  logic [AW-1:0]           pidx;
  logic [AW-1:0]           widx;

  logic                    kind_r;
  logic [KEY_W-1:0]        key_r;
  logic [CLIENT_W-1:0]     client_r;

  logic [REC_W-1:0]        rec;
  logic [CLIENT_COUNT-1:0] w_sh;
  logic [CIDX_W-1:0]       bidx;
  logic                    got_first;
  logic                    multi;
  logic [CLIENT_W-1:0]     first;

  logic                    p_a_v;
  logic [MSG_W-1:0]        p_a_msg;
  logic [CLIENT_W-1:0]     p_a_tgt;
  logic                    p_b_v;
  logic [STATUS_W-1:0]     p_status;

  // RAM side
  logic                    ram_we;
  logic [AW-1:0]           ram_raddr;
  logic [REC_W-1:0]        ram_rdata;
  logic [REC_W-1:0]        rec_next;

  // Decoded fields of the entry in hand
  logic [KEY_W-1:0]        rec_key;
  logic                    rec_held;
  logic [CLIENT_W-1:0]     rec_holder;
  logic                    rec_revoke;
  logic [CLIENT_COUNT-1:0] rec_waiters;
  logic [KEY_W-1:0]        rd_key;
  logic [CLIENT_COUNT-1:0] cbit;

  logic                    req_xfer;
  logic                    rsp_load;
  logic                    hit;
  logic                    scan_end;
  logic                    bits_done;

  assign {rec_key, rec_held, rec_holder, rec_revoke, rec_waiters} = rec;
  assign rd_key = ram_rdata[REC_W-1 -: KEY_W];

  // Clients at or above CLIENT_COUNT shift out and are never recorded as waiters.
  assign cbit = {{(CLIENT_COUNT-1){1'b0}}, 1'b1} << client_r;

  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign rsp_load  = (state == S_EMIT) && (!rsp_valid || !rsp_stall);

  assign ram_raddr = ridx[AW-1:0];
  assign ram_we    = (state == S_ACT);
  assign hit       = pend && (rd_key == key_r);
  assign scan_end  = !pend && (ridx == count);
  assign bits_done = (w_sh == '0) || multi;

  // Updated entry record, written back in the update cycle.
  always_comb begin
    rec_next = rec;
    if (kind_r == KIND_ACQUIRE) begin
      if (rec_held) begin
        rec_next = {rec_key, 1'b1, rec_holder, 1'b1, rec_waiters | cbit};
      end else begin
        rec_next = {rec_key, 1'b1, client_r, 1'b0, rec_waiters & ~cbit};
      end
    end else begin
      rec_next = {rec_key, 1'b0, rec_holder, 1'b0, rec_waiters};
    end
  end

  cld_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx),
    .wdata (rec_next),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ridx      <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
      p_a_v     <= 1'b0;
      p_b_v     <= 1'b0;
      got_first <= 1'b0;
      multi     <= 1'b0;
    end else begin
      // Raise valid on a load; drop it once its transfer completes.
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            kind_r   <= kind;
            key_r    <= lock_id[KEY_W-1:0];
            client_r <= client;
            ridx     <= '0;
            pend     <= 1'b0;
            p_a_v    <= 1'b0;
            p_b_v    <= 1'b0;
            state    <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (hit) begin
            rec   <= ram_rdata;
            widx  <= pidx;
            state <= S_ACT;
          end else if (scan_end) begin
            if (kind_r == KIND_RELEASE) begin
              p_status <= ST_NOENT;
              state    <= S_EMIT;
            end else if (count == CNT_W'(TABLE_ENTRIES)) begin
              p_status <= ST_FULL;
              state    <= S_EMIT;
            end else begin
              // Take the lowest free entry, cleared.
              rec   <= {key_r, {(REC_W-KEY_W){1'b0}}};
              widx  <= count[AW-1:0];
              count <= count + 1'b1;
              state <= S_ACT;
            end
          end else begin
            // Issue the next read while the previous one is compared.
            pend <= (ridx != count);
            pidx <= ridx[AW-1:0];
            if (ridx != count) begin
              ridx <= ridx + 1'b1;
            end
          end
        end

        S_ACT: begin
          if (kind_r == KIND_ACQUIRE) begin
            if (rec_held) begin
              p_status <= ST_RETRY;
              p_a_v    <= !rec_revoke;
              p_a_msg  <= MSG_REVOKE;
              p_a_tgt  <= rec_holder;
            end else begin
              p_status <= ST_OK;
            end
            state <= S_EMIT;
          end else begin
            p_status  <= ST_OK;
            w_sh      <= rec_waiters;
            bidx      <= '0;
            got_first <= 1'b0;
            multi     <= 1'b0;
            state     <= S_BITS;
          end
        end

        S_BITS: begin
          if (bits_done) begin
            p_a_v   <= got_first;
            p_a_msg <= MSG_RETRY;
            p_a_tgt <= first;
            p_b_v   <= multi;
            state   <= S_EMIT;
          end else begin
            if (w_sh[0]) begin
              if (got_first) begin
                multi <= 1'b1;
              end else begin
                got_first <= 1'b1;
                first     <= CLIENT_W'(bidx);
              end
            end
            w_sh <= w_sh >> 1;
            bidx <= bidx + 1'b1;
          end
        end

        S_EMIT: begin
          if (rsp_load) begin
            about_lock <= ID_W'(key_r);
            priority if (p_a_v) begin
              message       <= p_a_msg;
              target_client <= p_a_tgt;
              status        <= ST_OK;
              last          <= 1'b0;
              p_a_v         <= 1'b0;
            end else if (p_b_v) begin
              // Second callback of a release: revoke to the woken waiter.
              message       <= MSG_REVOKE;
              target_client <= p_a_tgt;
              status        <= ST_OK;
              last          <= 1'b0;
              p_b_v         <= 1'b0;
            end else begin
              message       <= MSG_REPLY;
              target_client <= client_r;
              status        <= p_status;
              last          <= 1'b1;
              state         <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_caching_lock_directory.sv =====
// Self-checking testbench for the caching lock directory: directed table, then random traffic.
module tb_caching_lock_directory;
  import cld_pkg::*;

  // Sizes of the directory under test (default build).
  localparam int DIR_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int CLIENTS     = CLIENT_COUNT_DEF;

  // Stimulus shape: a short directed script, then random requests that mostly hit a small
  // set of hot locks so that holders, waiters, revokes and retries pile up.
  localparam int SCRIPT_ROWS  = 16;
  localparam int RANDOM_REQS  = 320;
  localparam int TOTAL_REQS   = SCRIPT_ROWS + RANDOM_REQS;
  localparam int HOT_LOCKS    = 8;
  // Drain time after the last reply: one full-table scan, a waiter walk and some stall.
  localparam int DRAIN_CYCLES = 300;
  // Hang guard, set with a wide margin over the slowest correct run of 336 requests.
  localparam int CYCLE_LIMIT  = 600000;

  // One result transfer, field for field as the result ports carry it.
  typedef struct packed {
    logic [MSG_W-1:0]    message;
    logic [CLIENT_W-1:0] target_client;
    logic [ID_W-1:0]     about_lock;
    logic [STATUS_W-1:0] status;
    logic                last;
  } dir_msg_t;

  // One row of the directed script. Where fixed is set, the row carries its single reply's
  // status typed in; otherwise the lock table model supplies the expected results.
  typedef struct packed {
    logic                kind;
    logic [ID_W-1:0]     lock_id;
    logic [CLIENT_W-1:0] client;
    logic                fixed;
    logic [STATUS_W-1:0] status;
  } script_row_t;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  logic                kind;
  logic [ID_W-1:0]     lock_id;
  logic [CLIENT_W-1:0] client;
  logic                rsp_valid;
  logic                rsp_stall;
  logic [MSG_W-1:0]    message;
  logic [CLIENT_W-1:0] target_client;
  logic [ID_W-1:0]     about_lock;
  logic [STATUS_W-1:0] status;
  logic                last;

  // Lock table model: valid entries fill from index 0 and are never freed.
  bit                  tbl_valid   [DIR_ENTRIES];
  logic [ID_W-1:0]     tbl_lock    [DIR_ENTRIES];
  bit                  tbl_held    [DIR_ENTRIES];
  logic [CLIENT_W-1:0] tbl_holder  [DIR_ENTRIES];
  bit                  tbl_revoked [DIR_ENTRIES];
  logic [CLIENTS-1:0]  tbl_waiters [DIR_ENTRIES];

  dir_msg_t step_msgs [3];     // results of the latest modeled request, in order
  dir_msg_t pending_msgs [$];  // results still owed by the directory, oldest first

  logic [ID_W-1:0] hot_ids [HOT_LOCKS];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;

  // Directed script. Covers: unknown release at both id extremes, grant of a new lock,
  // first contender (revoke plus retry), later contender (retry only), holder acquiring
  // again, release with several waiters (retry and revoke to the lowest, which stays in
  // the mask), release by a non-holder, release with a single waiter, lowest and highest
  // client numbers.
  script_row_t script [SCRIPT_ROWS] = '{
    '{KIND_RELEASE, 32'h0000_0000, 4'd0,  1'b1, ST_NOENT},
    '{KIND_RELEASE, 32'hFFFF_FFFF, 4'd15, 1'b1, ST_NOENT},
    '{KIND_ACQUIRE, 32'h0000_0000, 4'd0,  1'b1, ST_OK},
    '{KIND_ACQUIRE, 32'hFFFF_FFFF, 4'd15, 1'b1, ST_OK},
    '{KIND_ACQUIRE, 32'h0000_0000, 4'd3,  1'b0, ST_OK},
    '{KIND_ACQUIRE, 32'h0000_0000, 4'd7,  1'b0, ST_OK},
    '{KIND_ACQUIRE, 32'h0000_0000, 4'd0,  1'b0, ST_OK},
    '{KIND_RELEASE, 32'h0000_0000, 4'd0,  1'b0, ST_OK},
    '{KIND_ACQUIRE, 32'h0000_0000, 4'd0,  1'b0, ST_OK},
    '{KIND_RELEASE, 32'h0000_0000, 4'd9,  1'b0, ST_OK},
    '{KIND_ACQUIRE, 32'h0000_0000, 4'd3,  1'b0, ST_OK},
    '{KIND_RELEASE, 32'h0000_0000, 4'd3,  1'b0, ST_OK},
    '{KIND_ACQUIRE, 32'hFFFF_FFFF, 4'd12, 1'b0, ST_OK},
    '{KIND_RELEASE, 32'hFFFF_FFFF, 4'd15, 1'b0, ST_OK},
    '{KIND_ACQUIRE, 32'h5A5A_5A5A, 4'd8,  1'b1, ST_OK},
    '{KIND_ACQUIRE, 32'hA5A5_A5A5, 4'd1,  1'b1, ST_OK}
  };

  caching_lock_directory dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .kind          (kind),
    .lock_id       (lock_id),
    .client        (client),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .message       (message),
    .target_client (target_client),
    .about_lock    (about_lock),
    .status        (status),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model one request against the lock table: update the table and fill step_msgs with
  // the callbacks and the reply it causes. Return how many results there are.
  function automatic int lock_table_step(input logic k, input logic [ID_W-1:0] id,
                                         input logic [CLIENT_W-1:0] c);
    int i;
    int e;
    int n;
    int first;
    logic [CLIENTS-1:0] cbit;
    logic [CLIENTS-1:0] w;
    e = -1;
    n = 0;
    first = 0;
    cbit = CLIENTS'(1) << c;
    for (i = 0; i < DIR_ENTRIES; i++)
      if (e < 0 && tbl_valid[i] && tbl_lock[i] == id) e = i;

    if (k == KIND_ACQUIRE) begin
      if (e < 0) begin
        // Take the lowest free entry; with none left, answer FULL and change nothing.
        for (i = 0; i < DIR_ENTRIES; i++)
          if (e < 0 && !tbl_valid[i]) e = i;
        if (e < 0) begin
          step_msgs[0] = '{MSG_REPLY, c, id, ST_FULL, 1'b1};
          return 1;
        end
        tbl_valid[e]   = 1'b1;
        tbl_lock[e]    = id;
        tbl_held[e]    = 1'b0;
        tbl_holder[e]  = '0;
        tbl_revoked[e] = 1'b0;
        tbl_waiters[e] = '0;
      end
      if (tbl_held[e]) begin
        // Contended: queue the requester, revoke the holder once per holding.
        tbl_waiters[e] |= cbit;
        if (!tbl_revoked[e]) begin
          tbl_revoked[e] = 1'b1;
          step_msgs[n] = '{MSG_REVOKE, tbl_holder[e], id, ST_OK, 1'b0};
          n++;
        end
        step_msgs[n] = '{MSG_REPLY, c, id, ST_RETRY, 1'b1};
        n++;
      end else begin
        tbl_held[e]    = 1'b1;
        tbl_holder[e]  = c;
        tbl_revoked[e] = 1'b0;
        tbl_waiters[e] &= ~cbit;
        step_msgs[n] = '{MSG_REPLY, c, id, ST_OK, 1'b1};
        n++;
      end
      return n;
    end

    if (e < 0) begin
      step_msgs[0] = '{MSG_REPLY, c, id, ST_NOENT, 1'b1};
      return 1;
    end
    tbl_held[e]    = 1'b0;
    tbl_revoked[e] = 1'b0;
    w = tbl_waiters[e];
    if (w != '0) begin
      // Wake the lowest waiter; warn it too when others still wait. It stays in the mask.
      for (i = CLIENTS - 1; i >= 0; i--)
        if (w[i]) first = i;
      step_msgs[n] = '{MSG_RETRY, CLIENT_W'(first), id, ST_OK, 1'b0};
      n++;
      if ($countones(w) > 1) begin
        step_msgs[n] = '{MSG_REVOKE, CLIENT_W'(first), id, ST_OK, 1'b0};
        n++;
      end
    end
    step_msgs[n] = '{MSG_REPLY, c, id, ST_OK, 1'b1};
    n++;
    return n;
  endfunction

  // Idling schedule over the run: sender light and receiver heavy, then swapped, then none.
  function automatic void pick_idling(input int n);
    if (n < TOTAL_REQS / 3) begin
      send_idle_pct  = 9;
      recv_stall_pct = 53;
    end else if (n < 2 * TOTAL_REQS / 3) begin
      send_idle_pct  = 53;
      recv_stall_pct = 9;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  endfunction

  // Present one request and hold it until the transfer. Drop valid only when a gap
  // follows, so valid never falls and rises within one step. On the transfer, record
  // what the directory owes for it.
  task automatic send_request(input logic k, input logic [ID_W-1:0] id,
                              input logic [CLIENT_W-1:0] c, input logic fixed,
                              input logic [STATUS_W-1:0] st);
    int gap;
    int n;
    int j;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= k;
    lock_id   <= id;
    client    <= c;
    // Values read here are the ones the directory saw at this edge.
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n = lock_table_step(k, id, c);
    if (fixed)
      pending_msgs.push_back('{MSG_REPLY, c, id, st, 1'b1});
    else
      for (j = 0; j < n; j++) pending_msgs.push_back(step_msgs[j]);
  endtask

  task automatic check_field(input string name, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: stall at random, compare every transfer with the oldest expectation,
  // and stop the run if it hangs.
  always @(posedge clk) begin
    dir_msg_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("caching_lock_directory: mismatch");
      $finish;
    end else begin
      if (!rst && rsp_valid && !rsp_stall) begin
        if (pending_msgs.size() == 0) begin
          $error("result with nothing expected: message %0d target %0d lock %0h status %0d",
                 message, target_client, about_lock, status);
          mismatches++;
        end else begin
          want = pending_msgs.pop_front();
          check_field("message", ID_W'(want.message), ID_W'(message));
          check_field("target_client", ID_W'(want.target_client), ID_W'(target_client));
          check_field("about_lock", want.about_lock, about_lock);
          check_field("status", ID_W'(want.status), ID_W'(status));
          check_field("last", ID_W'(want.last), ID_W'(last));
        end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int idx;
    logic k;
    logic [ID_W-1:0] id;
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    kind       <= KIND_ACQUIRE;
    lock_id    <= '0;
    client     <= '0;
    pick_idling(0);
    // Reset is held before traffic starts; the directory needs no clearing pass afterwards.
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (idx = 0; idx < SCRIPT_ROWS; idx++) begin
      pick_idling(idx);
      send_request(script[idx].kind, script[idx].lock_id, script[idx].client,
                   script[idx].fixed, script[idx].status);
    end

    // Hot locks: both id extremes plus a few random ids. Fresh random ids fill the table
    // partway through, after which new acquires get FULL and unknown releases NOENT.
    hot_ids[0] = 32'h0000_0000;
    hot_ids[1] = 32'hFFFF_FFFF;
    for (idx = 2; idx < HOT_LOCKS; idx++) hot_ids[idx] = $urandom();

    for (idx = 0; idx < RANDOM_REQS; idx++) begin
      pick_idling(SCRIPT_ROWS + idx);
      k  = ($urandom_range(99) < 55) ? KIND_ACQUIRE : KIND_RELEASE;
      id = ($urandom_range(99) < 55) ? hot_ids[$urandom_range(HOT_LOCKS - 1)] : $urandom();
      send_request(k, id, CLIENT_W'($urandom_range(CLIENTS - 1)), 1'b0, ST_OK);
    end
    req_valid <= 1'b0;

    // Wait out every owed result, then give stray results time to show up.
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("caching_lock_directory: match");
    else
      $display("caching_lock_directory: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cld_pkg.sv
rtl/cld_ram.sv
rtl/caching_lock_directory.sv
tb/tb_caching_lock_directory.sv
